// ===== design/assert_macros.svh =====
// Assertion macros shared by the segment clipper RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SRCB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("srcb assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define SRCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srcb assertion failed");

`endif

// ===== design/srcb_pkg.sv =====
// Shared types and constants of the segment region clipper.
// Used by every module of the block; depends on nothing.
package srcb_pkg;

  // Fixed field widths.
  localparam int unsigned CoordW  = 17;
  localparam int unsigned DiffW   = 18;
  localparam int unsigned RegW    = 15;
  localparam int unsigned RadSqW  = 30;
  localparam int unsigned SqW     = 36;
  localparam int unsigned CfgIdxW = 3;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_IS_CIRCLE = 3'd0,
    REG_X         = 3'd1,
    REG_Y         = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_HEIGHT    = 3'd4,
    REG_RADIUS    = 3'd5
  } srcb_reg_e;

  // Region description broadcast to all cells.
  typedef struct packed {
    logic              is_circle;
    logic [RegW-1:0]   x;
    logic [RegW-1:0]   y;
    logic [RegW-1:0]   width;
    logic [RegW-1:0]   height;
    logic [RadSqW-1:0] radius_sq;
  } srcb_region_t;

  // Segment word handed from cell to cell, with the best point found so far.
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    diff_t  d_x;
    diff_t  d_y;
    coord_t pt_x;
    coord_t pt_y;
  } srcb_seg_t;

endpackage

// ===== design/srcb_cfg_regs.sv =====
// Region configuration registers of the segment clipper.
// Depends on srcb_pkg; the squared radius is formed when the radius is written.
module srcb_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [srcb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [srcb_pkg::RegW-1:0]          cfg_data_i,
  output srcb_pkg::srcb_region_t             region_o
);
  import srcb_pkg::*;

  srcb_region_t      region_q, region_d;
  logic [RadSqW-1:0] radius_sq;

  assign radius_sq = cfg_data_i * cfg_data_i;

  // Register decode; writes to unknown indexes are dropped.
  always_comb begin
    region_d = region_q;
    if (cfg_valid_i) begin
      case (srcb_reg_e'(cfg_index_i))
        REG_IS_CIRCLE: region_d.is_circle = cfg_data_i[0];
        REG_X:         region_d.x         = cfg_data_i;
        REG_Y:         region_d.y         = cfg_data_i;
        REG_WIDTH:     region_d.width     = cfg_data_i;
        REG_HEIGHT:    region_d.height    = cfg_data_i;
        REG_RADIUS:    region_d.radius_sq = radius_sq;
        default:       region_d           = region_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q.is_circle <= 1'b0;
      region_q.x         <= '0;
      region_q.y         <= '0;
      region_q.width     <= RegW'(1);
      region_q.height    <= RegW'(1);
      region_q.radius_sq <= RadSqW'(1);
    end else begin
      region_q <= region_d;
    end
  end

  assign region_o = region_q;

endmodule

// ===== design/srcb_cell.sv =====
// One bisection step of the segment clipper, pipelined over four registers.
// Depends on srcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srcb_cell #(
  parameter int unsigned FRACTION_BITS = 20
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  srcb_pkg::srcb_region_t         region_i,
  input  logic                           valid_i,
  input  srcb_pkg::srcb_seg_t            seg_i,
  input  logic [FRACTION_BITS:0]         lo_i,
  input  logic [FRACTION_BITS:0]         hi1_i,
  output logic                           valid_o,
  output srcb_pkg::srcb_seg_t            seg_o,
  output logic [FRACTION_BITS:0]         lo_o,
  output logic [FRACTION_BITS:0]         hi1_o
);
  import srcb_pkg::*;

  // hi1 is the upper bound plus one, so both bounds stay non-negative.
  localparam int unsigned TW = FRACTION_BITS + 1;
  localparam int unsigned PW = DiffW + TW + 1;
  localparam logic [PW-1:0] Bias = {{(PW - FRACTION_BITS){1'b0}}, {FRACTION_BITS{1'b1}}};

  // Stage 1: midpoint and the two products d * mid.
  logic [TW:0]            mid_sum;
  logic [TW-1:0]          mid;
  logic signed [PW-1:0]   prod_x, prod_y;

  logic                   s1_valid_q;
  srcb_seg_t              s1_seg_q;
  logic [TW-1:0]          s1_lo_q, s1_hi1_q, s1_mid_q;
  logic signed [PW-1:0]   s1_px_q, s1_py_q;

  assign mid_sum = {1'b0, lo_i} + {1'b0, hi1_i};
  assign mid     = mid_sum[TW:1];
  assign prod_x  = $signed(seg_i.d_x) * $signed({1'b0, mid});
  assign prod_y  = $signed(seg_i.d_y) * $signed({1'b0, mid});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_seg_q <= seg_i;
      s1_lo_q  <= lo_i;
      s1_hi1_q <= hi1_i;
      s1_mid_q <= mid;
      s1_px_q  <= prod_x;
      s1_py_q  <= prod_y;
    end
  end

  // Stage 2: divide by 2^F rounding toward zero, form the probe point,
  // run the rectangle test and the offsets from the circle center.
  logic [PW-1:0]          adj_x, adj_y;
  logic [DiffW-1:0]       scaled_x, scaled_y;
  logic [DiffW-1:0]       probe_x, probe_y;
  logic [RegW:0]          right, bottom;
  logic                   rect_in;
  logic [DiffW-1:0]       off_x, off_y;

  logic                   s2_valid_q;
  srcb_seg_t              s2_seg_q;
  logic [TW-1:0]          s2_lo_q, s2_hi1_q, s2_mid_q;
  coord_t                 s2_probe_x_q, s2_probe_y_q;
  logic                   s2_rect_q;
  logic [DiffW-1:0]       s2_off_x_q, s2_off_y_q;

  assign adj_x    = s1_px_q[PW-1] ? (PW'(s1_px_q) + Bias) : PW'(s1_px_q);
  assign adj_y    = s1_py_q[PW-1] ? (PW'(s1_py_q) + Bias) : PW'(s1_py_q);
  assign scaled_x = adj_x[FRACTION_BITS +: DiffW];
  assign scaled_y = adj_y[FRACTION_BITS +: DiffW];
  assign probe_x  = {s1_seg_q.start_x[CoordW-1], s1_seg_q.start_x} + scaled_x;
  assign probe_y  = {s1_seg_q.start_y[CoordW-1], s1_seg_q.start_y} + scaled_y;

  assign right    = {1'b0, region_i.x} + {1'b0, region_i.width};
  assign bottom   = {1'b0, region_i.y} + {1'b0, region_i.height};
  assign rect_in  = ($signed(probe_x) >= $signed({3'b000, region_i.x}))
                 && ($signed(probe_x) <= $signed({2'b00, right}))
                 && ($signed(probe_y) >= $signed({3'b000, region_i.y}))
                 && ($signed(probe_y) <= $signed({2'b00, bottom}));
  assign off_x    = probe_x - {3'b000, region_i.x};
  assign off_y    = probe_y - {3'b000, region_i.y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_seg_q     <= s1_seg_q;
      s2_lo_q      <= s1_lo_q;
      s2_hi1_q     <= s1_hi1_q;
      s2_mid_q     <= s1_mid_q;
      s2_probe_x_q <= probe_x[CoordW-1:0];
      s2_probe_y_q <= probe_y[CoordW-1:0];
      s2_rect_q    <= rect_in;
      s2_off_x_q   <= off_x;
      s2_off_y_q   <= off_y;
    end
  end

  // Stage 3: squared distances from the circle center.
  logic signed [SqW-1:0]  sq_x, sq_y;

  logic                   s3_valid_q;
  srcb_seg_t              s3_seg_q;
  logic [TW-1:0]          s3_lo_q, s3_hi1_q, s3_mid_q;
  coord_t                 s3_probe_x_q, s3_probe_y_q;
  logic                   s3_rect_q;
  logic [SqW-1:0]         s3_sq_x_q, s3_sq_y_q;

  assign sq_x = $signed(s2_off_x_q) * $signed(s2_off_x_q);
  assign sq_y = $signed(s2_off_y_q) * $signed(s2_off_y_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en_i) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_seg_q     <= s2_seg_q;
      s3_lo_q      <= s2_lo_q;
      s3_hi1_q     <= s2_hi1_q;
      s3_mid_q     <= s2_mid_q;
      s3_probe_x_q <= s2_probe_x_q;
      s3_probe_y_q <= s2_probe_y_q;
      s3_rect_q    <= s2_rect_q;
      s3_sq_x_q    <= SqW'(sq_x);
      s3_sq_y_q    <= SqW'(sq_y);
    end
  end

  // Stage 4: circle test, pick the region test and move one bound.
  logic [SqW:0]           dist_sq;
  logic                   circle_in;
  logic                   probe_in;
  srcb_seg_t              seg_d;

  logic                   valid_q;
  srcb_seg_t              seg_q;
  logic [TW-1:0]          lo_q, hi1_q;

  assign dist_sq   = {1'b0, s3_sq_x_q} + {1'b0, s3_sq_y_q};
  assign circle_in = dist_sq <= (SqW + 1)'(region_i.radius_sq);
  assign probe_in  = region_i.is_circle ? circle_in : s3_rect_q;

  always_comb begin
    seg_d = s3_seg_q;
    if (probe_in) begin
      seg_d.pt_x = s3_probe_x_q;
      seg_d.pt_y = s3_probe_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      seg_q <= seg_d;
      lo_q  <= probe_in ? s3_mid_q : s3_lo_q;
      hi1_q <= probe_in ? s3_hi1_q : s3_mid_q;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;
  assign lo_o    = lo_q;
  assign hi1_o   = hi1_q;

  // The midpoint stays within the bounds, and the bounds never cross.
  `SRCB_ASSERT(cell_mid_in_bounds, s1_valid_q |-> (s1_mid_q >= s1_lo_q && s1_mid_q <= s1_hi1_q))
  `SRCB_ASSERT(cell_bounds_ordered, valid_q |-> lo_q <= hi1_q)

endmodule

// ===== design/srcb_out_skid.sv =====
// Output register with a one-word skid stage for the segment clipper.
// Depends on srcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srcb_out_skid (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  srcb_pkg::coord_t       end_x_i,
  input  srcb_pkg::coord_t       end_y_i,
  output logic                   full_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output srcb_pkg::coord_t       end_x_o,
  output srcb_pkg::coord_t       end_y_o
);
  import srcb_pkg::*;

  logic   out_valid_q, out_valid_d;
  logic   skid_valid_q, skid_valid_d;
  coord_t out_x_q, out_x_d, out_y_q, out_y_d;
  coord_t skid_x_q, skid_x_d, skid_y_q, skid_y_d;
  logic   take;

  assign take = out_valid_q & ~out_stall_i;

  // The skid word refills the output first; a new word parks in the skid
  // stage only when the output register is held.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_x_d      = out_x_q;
    out_y_d      = out_y_q;
    skid_x_d     = skid_x_q;
    skid_y_d     = skid_y_q;
    if (skid_valid_q) begin
      if (take) begin
        out_x_d      = skid_x_q;
        out_y_d      = skid_y_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_x_d     = end_x_i;
        out_y_d     = end_y_i;
      end else begin
        skid_valid_d = 1'b1;
        skid_x_d     = end_x_i;
        skid_y_d     = end_y_i;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q  <= out_x_d;
    out_y_q  <= out_y_d;
    skid_x_q <= skid_x_d;
    skid_y_q <= skid_y_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign end_x_o     = out_x_q;
  assign end_y_o     = out_y_q;

  // A parked word implies a held output word, and draining it leaves the
  // output register full and the skid stage empty.
  `SRCB_ASSERT(skid_implies_out, skid_valid_q |-> out_valid_q)
  `SRCB_ASSERT_NEXT(skid_refills_out, skid_valid_q && !out_stall_i, out_valid_q && !skid_valid_q)

endmodule

// ===== design/segment_region_clip_bisect_top.sv =====
// Top level of the segment region clipper: config registers, cell chain,
// output skid. Depends on srcb_pkg, srcb_cfg_regs, srcb_cell, srcb_out_skid.
//
// Clips the segment from a start point toward a target point to a circle or
// an inclusive rectangle by a bisection over a FRACTION_BITS fraction. Each of
// the BISECT_STEPS cells in the chain does one step in four pipeline
// registers (product, probe point, squares, bound update), and the result
// then passes through the output register. One word is accepted every cycle
// while in_stall_o is low. in_stall_o is high while the one-word skid stage
// holds a word, which is parked there only when the output is stalled; the
// whole chain then holds. Configuration writes are taken every cycle
// (cfg_ready_o is always high) and must only be issued while no word is in
// flight.
`include "assert_macros.svh"

module segment_region_clip_bisect_top #(
  parameter int unsigned BISECT_STEPS  = 24,
  parameter int unsigned FRACTION_BITS = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [srcb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [srcb_pkg::RegW-1:0]          cfg_data_i,
  // input segment channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [srcb_pkg::CoordW-1:0] start_x_i,
  input  logic signed [srcb_pkg::CoordW-1:0] start_y_i,
  input  logic signed [srcb_pkg::CoordW-1:0] goal_x_i,
  input  logic signed [srcb_pkg::CoordW-1:0] goal_y_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [srcb_pkg::CoordW-1:0] end_x_o,
  output logic signed [srcb_pkg::CoordW-1:0] end_y_o
);
  import srcb_pkg::*;

  localparam int unsigned TW = FRACTION_BITS + 1;
  // Upper bound plus one at the start: 2^F + 1.
  localparam logic [TW-1:0] Hi1Init = {1'b1, {(FRACTION_BITS - 1){1'b0}}, 1'b1};

  srcb_region_t  region;
  logic          en;
  logic          skid_full;
  logic          push;
  coord_t        res_x, res_y;

  logic          chain_valid [BISECT_STEPS+1];
  srcb_seg_t     chain_seg   [BISECT_STEPS+1];
  logic [TW-1:0] chain_lo    [BISECT_STEPS+1];
  logic [TW-1:0] chain_hi1   [BISECT_STEPS+1];

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  srcb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .region_o    (region)
  );

  // The chain moves whenever the skid stage has room.
  assign en         = ~skid_full;
  assign in_stall_o = skid_full;

  // Head of the chain: direction vector, full search interval, start point.
  assign chain_valid[0]       = in_valid_i;
  assign chain_seg[0].start_x = start_x_i;
  assign chain_seg[0].start_y = start_y_i;
  assign chain_seg[0].d_x     = {goal_x_i[CoordW-1], goal_x_i}
                              - {start_x_i[CoordW-1], start_x_i};
  assign chain_seg[0].d_y     = {goal_y_i[CoordW-1], goal_y_i}
                              - {start_y_i[CoordW-1], start_y_i};
  assign chain_seg[0].pt_x    = start_x_i;
  assign chain_seg[0].pt_y    = start_y_i;
  assign chain_lo[0]          = '0;
  assign chain_hi1[0]         = Hi1Init;

  // One cell per bisection step.
  for (genvar i = 0; i < BISECT_STEPS; i++) begin : g_cell
    srcb_cell #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .region_i (region),
      .valid_i  (chain_valid[i]),
      .seg_i    (chain_seg[i]),
      .lo_i     (chain_lo[i]),
      .hi1_i    (chain_hi1[i]),
      .valid_o  (chain_valid[i+1]),
      .seg_o    (chain_seg[i+1]),
      .lo_o     (chain_lo[i+1]),
      .hi1_o    (chain_hi1[i+1])
    );
  end

  // Result: the point kept at the final lower bound.
  assign push  = chain_valid[BISECT_STEPS] & en;
  assign res_x = chain_seg[BISECT_STEPS].pt_x;
  assign res_y = chain_seg[BISECT_STEPS].pt_y;

  srcb_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .end_x_i     (res_x),
    .end_y_i     (res_y),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .end_x_o     (end_x_o),
    .end_y_o     (end_y_o)
  );

  // A finished word at the chain tail waits while the chain is held, and the
  // input stays stalled as long as the output is stalled.
  `SRCB_ASSERT_NEXT(top_tail_held, chain_valid[BISECT_STEPS] && !en, chain_valid[BISECT_STEPS])
  `SRCB_ASSERT_NEXT(top_stall_holds, in_stall_o && out_stall_i, in_stall_o)

endmodule
